// ===== hw/rtl/terminal_escape_stripper_unit_assert.svh =====
// assertion macros for the terminal escape stripper
// each macro is one concurrent assertion, clocked on the rising edge,
// held off while the active-low reset is asserted
`ifndef TERMINAL_ESCAPE_STRIPPER_UNIT_ASSERT_SVH
`define TERMINAL_ESCAPE_STRIPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define TES_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication
`define TES_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== hw/rtl/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg
// types and character codes shared by the escape stripper files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tes_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StateW  = 3;

  // control and sequence characters
  localparam logic [ByteW-1:0] CH_NUL   = 8'd0;
  localparam logic [ByteW-1:0] CH_CAN   = 8'd24;
  localparam logic [ByteW-1:0] CH_SUB   = 8'd26;
  localparam logic [ByteW-1:0] CH_ESC   = 8'd27;
  localparam logic [ByteW-1:0] CH_CSI   = 8'd155;
  localparam logic [ByteW-1:0] CH_LBRK  = 8'h5B; // '['
  localparam logic [ByteW-1:0] CH_LPAR  = 8'h28; // '('
  localparam logic [ByteW-1:0] CH_RPAR  = 8'h29; // ')'
  localparam logic [ByteW-1:0] CH_HASH  = 8'h23; // '#'
  localparam logic [ByteW-1:0] CH_DCS   = 8'h50; // 'P'
  localparam logic [ByteW-1:0] CH_ED    = 8'h4A; // 'J'
  localparam logic [ByteW-1:0] CH_QMARK = 8'h3F; // '?'
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3B; // ';'
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39; // '9'

  typedef enum logic [ActionW-1:0] {
    ACT_DROP  = 2'd0,
    ACT_PASS  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [StateW-1:0] {
    ST_TEXT      = 3'd0,
    ST_ESC       = 3'd1,
    ST_CSI       = 3'd2,
    ST_PRIV      = 3'd3,
    ST_G0        = 3'd4,
    ST_G1        = 3'd5,
    ST_LINE_ATTR = 3'd6,
    ST_DCS       = 3'd7
  } parse_state_e;

  // verdict on one byte
  typedef struct packed {
    action_e      action;
    parse_state_e next_state;
  } verdict_t;

endpackage

// ===== hw/rtl/tes_in_if.sv =====
// ----------------------------------------------------------------------------
// tes_in_if
// input channel: one raw terminal byte per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tes_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);

endinterface

// ===== hw/rtl/tes_out_if.sv =====
// ----------------------------------------------------------------------------
// tes_out_if
// result channel: action code and echoed byte per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tes_out_if;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] out_byte;

  modport source (output valid, output action, output out_byte, input ready);
  modport sink   (input valid, input action, input out_byte, output ready);

endinterface

// ===== hw/rtl/tes_classify.sv =====
// ----------------------------------------------------------------------------
// tes_classify
// decides pass, drop or clear for one byte and the next parser state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tes_classify (
  input  logic [7:0]            byte_i,
  input  tes_pkg::parse_state_e state_i,
  output tes_pkg::verdict_t     verdict_o
);
  import tes_pkg::*;

  logic is_digit;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);

  always_comb begin
    verdict_o.action     = ACT_DROP;
    verdict_o.next_state = state_i;
    if (byte_i == CH_NUL) begin
      verdict_o.action = ACT_PASS;
    end else if (byte_i == CH_CAN || byte_i == CH_SUB) begin
      verdict_o.next_state = ST_TEXT;
    end else if (byte_i == CH_ESC) begin
      verdict_o.next_state = ST_ESC;
    end else if (byte_i == CH_CSI) begin
      verdict_o.next_state = ST_CSI;
    end else begin
      case (state_i)
        ST_TEXT: begin
          verdict_o.action = ACT_PASS;
        end
        ST_ESC: begin
          if (byte_i == CH_LBRK) begin
            verdict_o.next_state = ST_CSI;
          end else if (byte_i == CH_LPAR) begin
            verdict_o.next_state = ST_G0;
          end else if (byte_i == CH_RPAR) begin
            verdict_o.next_state = ST_G1;
          end else if (byte_i == CH_HASH) begin
            verdict_o.next_state = ST_LINE_ATTR;
          end else if (byte_i == CH_DCS) begin
            verdict_o.next_state = ST_DCS;
          end else begin
            verdict_o.next_state = ST_TEXT;
          end
        end
        ST_CSI: begin
          if (byte_i == CH_ED) begin
            verdict_o.action     = ACT_CLEAR;
            verdict_o.next_state = ST_TEXT;
          end else if (is_digit || byte_i == CH_SEMI) begin
            verdict_o.next_state = ST_CSI;
          end else if (byte_i == CH_QMARK) begin
            verdict_o.next_state = ST_PRIV;
          end else begin
            verdict_o.next_state = ST_TEXT;
          end
        end
        ST_PRIV: begin
          if (!is_digit) begin
            verdict_o.next_state = ST_TEXT;
          end
        end
        ST_G0, ST_G1, ST_LINE_ATTR: begin
          verdict_o.next_state = ST_TEXT;
        end
        ST_DCS: begin
          verdict_o.next_state = ST_DCS;
        end
        default: begin
          verdict_o.next_state = ST_TEXT;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/terminal_escape_stripper_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_stripper_unit: vt100 escape filter, one byte per cycle unless the output stalls
// path from input beat to result valid: input reg, then result reg
// throughput 1 beat per cycle unless the output stalls, set by the single state register update
// reset: asynchronous active low, parser back to plain text, stages empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "terminal_escape_stripper_unit_assert.svh"

module terminal_escape_stripper_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tes_in_if.sink    in_i,
  tes_out_if.source out_o
);
  import tes_pkg::*;

  // input register stage
  logic         s1_valid_q;
  logic [7:0]   s1_byte_q;

  // result register stage
  logic         res_valid_q;
  action_e      res_action_q;
  logic [7:0]   res_byte_q;

  // parser state, advanced as each byte moves into the result register
  parse_state_e state_q;
  parse_state_e state_d;

  verdict_t     verdict;
  logic         res_free;
  logic         advance;
  logic         in_take;

  // result register can load when empty or being drained this cycle
  assign res_free = !res_valid_q || out_o.ready;
  // byte in the input register gets classified and moves on
  assign advance  = s1_valid_q && res_free;
  // input register can take a beat when empty or emptying
  assign in_take  = in_i.valid && in_i.ready;

  assign in_i.ready = !s1_valid_q || advance;

  // classification sits between the two registers
  tes_classify u_classify (
    .byte_i    (s1_byte_q),
    .state_i   (state_q),
    .verdict_o (verdict)
  );

  assign state_d = advance ? verdict.next_state : state_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= ST_TEXT;
    end else begin
      state_q <= state_d;
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (res_free) begin
        res_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.in_byte;
    end
    if (advance) begin
      res_action_q <= verdict.action;
      res_byte_q   <= s1_byte_q;
    end
  end

  assign out_o.valid    = res_valid_q;
  assign out_o.action   = res_action_q;
  assign out_o.out_byte = res_byte_q;

  // ---- assertions ----

  // clear-screen only completes a csi sequence
  `TES_ASSERT_IMPL(a_clear_from_csi, clk_i, rst_ni, advance && verdict.action == ACT_CLEAR, state_q == ST_CSI, "clear outside csi")

  // a null byte never disturbs the parser
  `TES_ASSERT_NEXT(a_nul_keeps_state, clk_i, rst_ni, advance && s1_byte_q == CH_NUL, $stable(state_q), "nul moved parser state")

  // device control holds until a starter or cancel byte
  `TES_ASSERT_NEXT(a_dcs_sticky, clk_i, rst_ni, advance && state_q == ST_DCS && s1_byte_q != CH_ESC && s1_byte_q != CH_CSI && s1_byte_q != CH_CAN && s1_byte_q != CH_SUB, state_q == ST_DCS, "left dcs early")

  // input only stalls when both stages are full and the result is blocked
  `TES_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_i.ready, s1_valid_q && res_valid_q && !out_o.ready, "spurious input stall")

endmodule
